[sv/rawr_pkg.sv]
// Package for running_average_with_range_core: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package rawr_pkg;
   localparam int unsigned CfgIdxW = 2;
   localparam int unsigned CfgDataW = 16;
   localparam logic [CfgIdxW-1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [CfgIdxW-1:0] CSR_AVG_LEN = 2'd1;
   localparam logic [CfgIdxW-1:0] CSR_CALIBRATION = 2'd2;
   localparam logic [CfgIdxW-1:0] CSR_FREEZE = 2'd3;
   localparam int unsigned DivW = 64;
   localparam logic [1:0] CHG_NONE = 2'd0;
   localparam logic [1:0] CHG_MAX = 2'd1;
   localparam logic [1:0] CHG_MIN = 2'd2;

   // Divider control: start request and status.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

[sv/running_average_with_range_core.sv]
// Top level of the running average with range tracker.
// Depends on rawr_pkg and rawr_div.
`timescale 1ns / 1ps
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req_sample
//  rsp     | out | rsp_valid/rsp_ready  | average .. error_max
//  csr     | in  | csr_we               | csr_index, csr_wdata
// Each sample passes from its accepted beat through a square step, two passes
// through the shared 64-step divider (error filter, then average), a range
// compare and a bounds update to rsp_valid. No new beat is taken while a
// sample is in flight. req_ready is high only when idle and the output register
// is empty or being drained. Synchronous active-high reset returns control,
// config, accumulator and range state to reset values, but not the captured
// sample, delta, warm flag or change code; results stall in rsp until taken.
module running_average_with_range_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_average,
   output logic signed [31:0] rsp_range_min,
   output logic signed [31:0] rsp_range_max,
   output logic [1:0] rsp_range_change,
   output logic signed [31:0] rsp_midpoint,
   output logic [30:0] rsp_half_span,
   output logic [47:0] rsp_mean_sq_error,
   output logic [47:0] rsp_error_min,
   output logic [47:0] rsp_error_max,
   input  logic csr_we,
   input  logic [rawr_pkg::CfgIdxW-1:0] csr_index,
   input  logic [rawr_pkg::CfgDataW-1:0] csr_wdata
);
   import rawr_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_SQ = 6'b000010, ST_EDIV = 6'b000100,
      ST_ADIV = 6'b001000, ST_RANGE = 6'b010000, ST_OUT = 6'b100000
   } state_type;

   localparam logic signed [63:0] S32MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32MIN = -64'sd2147483648;
   localparam logic signed [63:0] S48MAX = 64'sh7FFFFFFFFFFF;
   localparam logic signed [63:0] S48MIN = -64'sh800000000000;
   localparam logic [47:0] U48MAX = '1;

   state_type st_ff, st_in;
   logic [15:0] wlen_ff, alen_ff;
   logic cal_ff, frz_ff;
   logic signed [31:0] avg_ff, v_ff, tmin_ff, tmax_ff, mid_ff, half_ff;
   logic signed [47:0] wsum_ff;
   logic [15:0] cnt_ff;
   logic [47:0] eavg_ff, elo_ff, ehi_ff;
   logic warm_ff;
   logic signed [32:0] delta_ff;
   logic [1:0] chg_ff;
   logic rv_ff;

   logic div_start, div_done;
   logic signed [DivW-1:0] div_num, div_q;
   logic [15:0] div_den;

   // sample promoted to fixed point, saturated to 32 bits
   logic signed [63:0] v_wide, v_sat;
   assign v_wide = 64'(req_sample) <<< FRAC_BITS;
   assign v_sat = v_wide > S32MAX ? S32MAX : (v_wide < S32MIN ? S32MIN : v_wide);

   // squared deviation, saturated to 48 bits, used while in ST_SQ
   logic [32:0] mag;
   logic [65:0] sq;
   logic [65:0] qd_w;
   logic [47:0] qd_sat;
   assign mag = delta_ff[32] ? 33'(-delta_ff) : 33'(delta_ff);
   assign sq = 66'(mag) * 66'(mag);
   assign qd_w = sq >> FRAC_BITS;
   assign qd_sat = qd_w > 66'(U48MAX) ? U48MAX : qd_w[47:0];

   logic signed [63:0] wsum_next, avg_next, eavg_next, d_val;
   logic [15:0] n_val;
   assign n_val = cnt_ff + 16'd1;
   assign wsum_next = 64'(wsum_ff) + 64'(v_ff) > S48MAX ? S48MAX :
                      (64'(wsum_ff) + 64'(v_ff) < S48MIN ? S48MIN :
                       64'(wsum_ff) + 64'(v_ff));

   logic ready_int;
   assign ready_int = st_ff == ST_IDLE && (!rv_ff || rsp_ready);
   assign req_ready = ready_int;

   always_comb begin
      st_in = st_ff; div_start = 1'b0; div_num = '0; div_den = 16'd1;
      case (st_ff)
         ST_IDLE: if (req_valid && ready_int) st_in = ST_SQ;
         ST_SQ: begin
            div_start = 1'b1;
            div_num = 64'(signed'({16'd0, qd_sat})) - 64'(signed'({16'd0, eavg_ff}));
            div_den = warm_ff ? n_val : (wlen_ff == 16'd0 ? 16'd1 : wlen_ff);
            st_in = ST_EDIV;
         end
         ST_EDIV: if (div_done) begin
            div_start = 1'b1;
            div_num = warm_ff ? wsum_next : 64'(delta_ff);
            div_den = warm_ff ? n_val : (alen_ff == 16'd0 ? 16'd1 : alen_ff);
            st_in = ST_ADIV;
         end
         ST_ADIV: if (div_done) st_in = ST_RANGE;
         ST_RANGE: st_in = ST_OUT;
         ST_OUT: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // pick the average update from the second division
   always_comb begin
      avg_next = warm_ff ? div_q : 64'(avg_ff) + div_q;
      if (avg_next > S32MAX) avg_next = S32MAX;
      else if (avg_next < S32MIN) avg_next = S32MIN;
   end
   assign eavg_next = 64'(signed'({16'd0, eavg_ff})) + div_q;
   assign d_val = cal_ff ? 64'(avg_ff) : 64'(v_ff);

   // new minimum wins over new maximum
   logic [1:0] chg_next;
   always_comb begin
      chg_next = CHG_NONE;
      if (d_val > 64'(tmax_ff)) chg_next = CHG_MAX;
      if (d_val < 64'(tmin_ff)) chg_next = CHG_MIN;
   end

   rawr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   logic signed [32:0] span;
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rv_ff <= 1'b0;
         wlen_ff <= 16'd16; alen_ff <= 16'd16; cal_ff <= 1'b0; frz_ff <= 1'b0;
         avg_ff <= '0; wsum_ff <= '0; cnt_ff <= '0;
         tmin_ff <= 32'sh7FFFFFFF; tmax_ff <= 32'sh80000000;
         mid_ff <= '0; half_ff <= '0;
         eavg_ff <= '0; elo_ff <= U48MAX; ehi_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_LEN: wlen_ff <= csr_wdata;
               CSR_AVG_LEN: alen_ff <= csr_wdata;
               CSR_CALIBRATION: cal_ff <= csr_wdata[0];
               CSR_FREEZE: frz_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rv_ff && rsp_ready && st_ff != ST_OUT) rv_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: if (req_valid && ready_int) begin
               v_ff <= 32'(v_sat);
               delta_ff <= 33'(v_sat) - 33'(avg_ff);
               warm_ff <= cnt_ff < wlen_ff;
            end
            ST_EDIV: if (div_done) begin
               eavg_ff <= eavg_next[47:0];
               if (!warm_ff) begin
                  if (eavg_next[47:0] > ehi_ff) ehi_ff <= eavg_next[47:0];
                  if (eavg_next[47:0] < elo_ff) elo_ff <= eavg_next[47:0];
               end
               if (warm_ff) wsum_ff <= wsum_next[47:0];
            end
            ST_ADIV: if (div_done) begin
               avg_ff <= avg_next[31:0];
               if (warm_ff) cnt_ff <= n_val;
            end
            ST_RANGE: begin
               chg_ff <= chg_next;
               if (d_val > 64'(tmax_ff)) tmax_ff <= d_val[31:0];
               if (d_val < 64'(tmin_ff)) tmin_ff <= d_val[31:0];
            end
            ST_OUT: begin
               if (chg_ff != CHG_NONE && !frz_ff) begin
                  mid_ff <= 32'((33'(tmax_ff) + 33'(tmin_ff)) / 2);
                  half_ff <= 32'((span == 33'sd0 ? 33'sd1 <<< FRAC_BITS : span) / 2);
               end
               rv_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
   assign span = 33'(tmax_ff) - 33'(tmin_ff);

   assign rsp_valid = rv_ff;
   assign rsp_average = avg_ff;
   assign rsp_range_min = tmin_ff;
   assign rsp_range_max = tmax_ff;
   assign rsp_range_change = chg_ff;
   assign rsp_midpoint = mid_ff;
   assign rsp_half_span = half_ff[30:0];
   assign rsp_mean_sq_error = eavg_ff;
   assign rsp_error_min = elo_ff;
   assign rsp_error_max = ehi_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(st_ff) == ST_OUT) else $error("result without work");
   a_range: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && chg_ff != CHG_NONE) |-> tmin_ff <= tmax_ff) else $error("range inverted");
endmodule

[sv/rawr_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rawr_pkg.
`timescale 1ns / 1ps
module rawr_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [rawr_pkg::DivW-1:0] dividend,
   input  logic [15:0] divisor,
   output logic done,
   output logic signed [rawr_pkg::DivW-1:0] quotient
);
   import rawr_pkg::*;
   logic [DivW-1:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [17:0] trial;
   logic [DivW-1:0] mag;

   assign mag = dividend[DivW-1] ? DivW'(-dividend) : DivW'(dividend);
   assign trial = {r_ff, q_ff[DivW-1]} - {2'b0, d_ff};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = mag; r_in = '0; d_in = divisor; cnt_in = 7'(DivW);
         neg_in = dividend[DivW-1]; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            r_in = trial[16:0];
            q_in = {q_ff[DivW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[15:0], q_ff[DivW-1]};
            q_in = {q_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? DivW'(-q_ff) : DivW'(q_ff);
endmodule
